[design/flash_command_sequencer_macros.svh]
// assertion macros shared by the flash command sequencer rtl
`ifndef FLASH_COMMAND_SEQUENCER_MACROS_SVH
`define FLASH_COMMAND_SEQUENCER_MACROS_SVH

`ifndef ASSERT_OFF
// property checked at every edge outside reset
`define FCS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("flash command sequencer assertion failed");
// consequence checked at the edge after the trigger
`define FCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("flash command sequencer assertion failed");
`else
`define FCS_ASSERT(label, clk, rst, prop)
`define FCS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[design/fcs_pkg.sv]
`default_nettype none

package fcs_pkg;

  // unlock offsets and command words
  localparam logic [15:0] UNLOCK_A       = 16'h5555;
  localparam logic [15:0] UNLOCK_B       = 16'h2AAA;
  localparam logic [23:0] CMD_ID_ENTER   = 24'hAA5590;
  localparam logic [23:0] CMD_ID_EXIT    = 24'hAA55F0;
  localparam logic [23:0] CMD_BANK       = 24'hAA55B0;
  localparam logic [23:0] CMD_ERASE      = 24'hAA5580;
  localparam logic [23:0] CMD_ERASE_CHIP = 24'hAA5510;
  localparam logic [23:0] CMD_PROGRAM    = 24'hAA55A0;
  localparam logic [7:0]  RESET_BYTE     = 8'hF0;
  localparam logic [7:0]  ERASED_BYTE    = 8'hFF;
  localparam logic [15:0] SECTOR_MASK    = 16'hF000;

  localparam int ERASE_SECTOR_BYTES   = 4096;
  localparam int PROGRAM_SECTOR_BYTES = 128;

  // config register indexes
  localparam logic [1:0] CFG_CHIP_SIZE    = 2'd0;
  localparam logic [1:0] CFG_SECTOR_PROG  = 2'd1;
  localparam logic [1:0] CFG_MANUFACTURER = 2'd2;
  localparam logic [1:0] CFG_DEVICE       = 2'd3;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_SEQ     = 3'd1,
    ST_UNKNOWN_CMD = 3'd2,
    ST_BUSY_READ   = 3'd3,
    ST_RANGE       = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    SEQ_READY, SEQ_ID, SEQ_CMD1, SEQ_CMD2, SEQ_ERASE, SEQ_ERASE1, SEQ_ERASE2,
    SEQ_SECTOR_PROG, SEQ_BYTE_PROG, SEQ_BANK
  } seq_state_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_READ, OP_ID, OP_WRITE, OP_ERASE
  } op_t;

  typedef struct packed {
    logic        mode;
    logic [15:0] offset;
    logic [7:0]  write_data;
  } access_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [2:0] status;
    logic       contents_changed;
  } result_t;

  typedef struct packed {
    logic       chip_size_select;
    logic       sector_program_mode;
    logic [7:0] manufacturer_code;
    logic [7:0] device_code;
  } cfg_t;

  typedef struct packed {
    seq_state_t  seq;
    logic [23:0] cmd;
    logic        bank;
    logic [15:0] start;
    logic        start_valid;
  } seq_regs_t;

  typedef struct packed {
    status_t    status;
    op_t        op;
    seq_regs_t  next;
    logic       set_changed;
    logic [7:0] id_data;
  } dec_t;

endpackage

`default_nettype wire

[design/fcs_ram.sv]
`default_nettype none

module fcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 131072
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

`default_nettype wire

[design/fcs_decode.sv]
`default_nettype none

module fcs_decode #(
  parameter int ARRAY_BYTES = 131072
) (
  input  wire fcs_pkg::access_t              acc,
  input  wire fcs_pkg::cfg_t                 cfg,
  input  wire fcs_pkg::seq_regs_t            regs,
  output fcs_pkg::dec_t                      dec,
  output logic [$clog2(ARRAY_BYTES)-1:0]     mem_addr,
  output logic [$clog2(ARRAY_BYTES)-1:0]     sweep_last
);

  localparam int          AW        = $clog2(ARRAY_BYTES);
  localparam logic [17:0] BANK_SIZE = 18'h10000;
  localparam logic [17:0] CAP_TWO   = (ARRAY_BYTES < 131072) ? 18'(ARRAY_BYTES) : 18'h20000;
  localparam logic [17:0] ERASE_LEN = 18'(fcs_pkg::ERASE_SECTOR_BYTES);
  localparam logic [15:0] PROG_SPAN = 16'(fcs_pkg::PROGRAM_SECTOR_BYTES - 1);

  logic [17:0] cap;
  logic [17:0] bank_add;
  logic [17:0] idx;
  logic [17:0] idx_s;
  logic [17:0] sec_last;
  logic [17:0] cap_last;
  logic [23:0] shifted;
  logic [15:0] start_eff;
  logic        in_range;

  always_comb begin
    cap       = cfg.chip_size_select ? CAP_TWO : BANK_SIZE;
    bank_add  = (cfg.chip_size_select && regs.bank) ? BANK_SIZE : 18'd0;
    idx       = {2'b00, acc.offset} + bank_add;
    idx_s     = {2'b00, acc.offset & fcs_pkg::SECTOR_MASK} + bank_add;
    sec_last  = idx_s + (ERASE_LEN - 18'd1);
    cap_last  = cap - 18'd1;
    shifted   = {regs.cmd[15:0], acc.write_data};
    start_eff = regs.start_valid ? regs.start : acc.offset;
    in_range  = idx < cap;

    dec.status      = fcs_pkg::ST_OK;
    dec.op          = fcs_pkg::OP_NONE;
    dec.next        = regs;
    dec.set_changed = 1'b0;
    dec.id_data     = 8'd0;
    mem_addr        = idx[AW-1:0];
    sweep_last      = idx[AW-1:0];

    if (acc.mode) begin
      unique case (regs.seq)
        fcs_pkg::SEQ_READY, fcs_pkg::SEQ_ID: begin
          if (acc.offset != fcs_pkg::UNLOCK_A) begin
            dec.status = fcs_pkg::ST_BAD_SEQ;
          end else if (acc.write_data == fcs_pkg::RESET_BYTE) begin
            dec.next.seq = fcs_pkg::SEQ_READY;
          end else begin
            dec.next.cmd = {16'd0, acc.write_data};
            dec.next.seq = fcs_pkg::SEQ_CMD1;
          end
        end
        fcs_pkg::SEQ_CMD1, fcs_pkg::SEQ_ERASE1: begin
          if (acc.offset != fcs_pkg::UNLOCK_B) begin
            dec.status = fcs_pkg::ST_BAD_SEQ;
          end else begin
            dec.next.cmd = shifted;
            dec.next.seq = (regs.seq == fcs_pkg::SEQ_CMD1) ? fcs_pkg::SEQ_CMD2
                                                           : fcs_pkg::SEQ_ERASE2;
          end
        end
        fcs_pkg::SEQ_CMD2: begin
          if (acc.offset != fcs_pkg::UNLOCK_A) begin
            dec.status = fcs_pkg::ST_BAD_SEQ;
          end else begin
            dec.next.cmd = shifted;
            unique case (shifted)
              fcs_pkg::CMD_ID_ENTER: dec.next.seq = fcs_pkg::SEQ_ID;
              fcs_pkg::CMD_ID_EXIT:  dec.next.seq = fcs_pkg::SEQ_READY;
              fcs_pkg::CMD_BANK:     dec.next.seq = fcs_pkg::SEQ_BANK;
              fcs_pkg::CMD_ERASE:    dec.next.seq = fcs_pkg::SEQ_ERASE;
              fcs_pkg::CMD_PROGRAM: begin
                dec.next.seq = cfg.sector_program_mode ? fcs_pkg::SEQ_SECTOR_PROG
                                                       : fcs_pkg::SEQ_BYTE_PROG;
              end
              default: begin
                // unknown command keeps the third-byte step
                dec.status = fcs_pkg::ST_UNKNOWN_CMD;
                dec.next   = regs;
              end
            endcase
          end
        end
        fcs_pkg::SEQ_ERASE: begin
          if (acc.offset != fcs_pkg::UNLOCK_A) begin
            dec.status = fcs_pkg::ST_BAD_SEQ;
          end else begin
            dec.next.cmd = {16'd0, acc.write_data};
            dec.next.seq = fcs_pkg::SEQ_ERASE1;
          end
        end
        fcs_pkg::SEQ_ERASE2: begin
          if (acc.offset == fcs_pkg::UNLOCK_A && shifted == fcs_pkg::CMD_ERASE_CHIP) begin
            dec.op     = fcs_pkg::OP_ERASE;
            mem_addr   = '0;
            sweep_last = cap_last[AW-1:0];
          end else if (idx_s + ERASE_LEN > cap) begin
            dec.status = fcs_pkg::ST_RANGE;
          end else begin
            dec.op     = fcs_pkg::OP_ERASE;
            mem_addr   = idx_s[AW-1:0];
            sweep_last = sec_last[AW-1:0];
          end
          if (dec.status == fcs_pkg::ST_OK) begin
            dec.next.cmd    = shifted;
            dec.next.seq    = fcs_pkg::SEQ_READY;
            dec.set_changed = 1'b1;
          end
        end
        fcs_pkg::SEQ_SECTOR_PROG: begin
          if (!in_range) begin
            dec.status = fcs_pkg::ST_RANGE;
          end else begin
            dec.op               = fcs_pkg::OP_WRITE;
            dec.set_changed      = 1'b1;
            dec.next.start       = start_eff;
            dec.next.start_valid = 1'b1;
            if (acc.offset - PROG_SPAN == start_eff) begin
              dec.next.start_valid = 1'b0;
              dec.next.seq         = fcs_pkg::SEQ_READY;
            end
          end
        end
        fcs_pkg::SEQ_BYTE_PROG: begin
          if (!in_range) begin
            dec.status = fcs_pkg::ST_RANGE;
          end else begin
            dec.op          = fcs_pkg::OP_WRITE;
            dec.set_changed = 1'b1;
            dec.next.seq    = fcs_pkg::SEQ_READY;
          end
        end
        fcs_pkg::SEQ_BANK: begin
          if (acc.offset != 16'd0) begin
            dec.status = fcs_pkg::ST_BAD_SEQ;
          end else if (acc.write_data > 8'd1) begin
            dec.status = fcs_pkg::ST_RANGE;
          end else begin
            dec.next.bank = acc.write_data[0];
            dec.next.seq  = fcs_pkg::SEQ_READY;
          end
        end
        default: begin
          dec.next = regs;
        end
      endcase
    end else begin
      unique case (regs.seq)
        fcs_pkg::SEQ_ID: begin
          if (acc.offset == 16'd0) begin
            dec.op      = fcs_pkg::OP_ID;
            dec.id_data = cfg.manufacturer_code;
          end else if (acc.offset == 16'd1) begin
            dec.op      = fcs_pkg::OP_ID;
            dec.id_data = cfg.device_code;
          end else begin
            dec.status = fcs_pkg::ST_RANGE;
          end
        end
        fcs_pkg::SEQ_READY, fcs_pkg::SEQ_SECTOR_PROG: begin
          if (!in_range) begin
            dec.status = fcs_pkg::ST_RANGE;
          end else begin
            dec.op = fcs_pkg::OP_READ;
          end
        end
        default: begin
          dec.status = fcs_pkg::ST_BUSY_READ;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[design/flash_command_sequencer.sv]
// read or write word: accepted in idle, result word registered once the output is free; no new word
// is taken until then. sector erase walks the 4096 bytes of its sector, chip erase every byte of capacity
// rate is set by the single byte-wide array port, one byte per cycle
// after reset the array is swept to 0xff, all ARRAY_BYTES bytes, before the first word
// is taken; config writes are taken at all times
`default_nettype none
`include "flash_command_sequencer_macros.svh"

module flash_command_sequencer #(
  parameter int ARRAY_BYTES = 131072
) (
  input  wire logic             clk,
  input  wire logic             rst,
  // access words
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire fcs_pkg::access_t req,
  // result words
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output fcs_pkg::result_t      rsp,
  // register writes
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [7:0]       cfg_data
);

  localparam int AW = $clog2(ARRAY_BYTES);

  // array walk runs for the reset clear and for erases
  typedef enum logic [1:0] {PH_CLEAR, PH_IDLE, PH_SWEEP, PH_RESP} phase_t;

  phase_t             phase;
  fcs_pkg::cfg_t      cfg;
  fcs_pkg::seq_regs_t regs;
  logic               changed_flag;
  logic [AW-1:0]      sweep_addr;
  logic [AW-1:0]      sweep_last;

  // held from acceptance until the result word is loaded
  fcs_pkg::status_t   pend_status;
  fcs_pkg::op_t       pend_op;
  logic [7:0]         pend_id;

  fcs_pkg::dec_t      dec;
  logic [AW-1:0]      dec_addr;
  logic [AW-1:0]      dec_last;

  logic               accept;
  logic               sweep_done;
  logic               ram_en;
  logic               ram_we;
  logic [AW-1:0]      ram_addr;
  logic [7:0]         ram_wdata;
  logic [7:0]         ram_rdata;

  assign req_ready  = (phase == PH_IDLE);
  assign cfg_ready  = 1'b1;
  assign accept     = req_valid && req_ready;
  assign sweep_done = (sweep_addr == sweep_last);

  fcs_decode #(
    .ARRAY_BYTES (ARRAY_BYTES)
  ) u_decode (
    .acc        (req),
    .cfg        (cfg),
    .regs       (regs),
    .dec        (dec),
    .mem_addr   (dec_addr),
    .sweep_last (dec_last)
  );

  // array port: the walk owns it while clearing or erasing, else the accepted word
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = dec_addr;
    ram_wdata = req.write_data;
    unique case (phase)
      PH_CLEAR, PH_SWEEP: begin
        ram_en    = 1'b1;
        ram_we    = 1'b1;
        ram_addr  = sweep_addr;
        ram_wdata = fcs_pkg::ERASED_BYTE;
      end
      PH_IDLE: begin
        ram_en = accept && (dec.op == fcs_pkg::OP_READ || dec.op == fcs_pkg::OP_WRITE);
        ram_we = (dec.op == fcs_pkg::OP_WRITE);
      end
      default: begin
        ram_en = 1'b0;
      end
    endcase
  end

  fcs_ram #(
    .WIDTH (8),
    .DEPTH (ARRAY_BYTES)
  ) u_array (
    .clk   (clk),
    .en    (ram_en),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      phase                   <= PH_CLEAR;
      sweep_addr              <= '0;
      sweep_last              <= AW'(ARRAY_BYTES - 1);
      cfg.chip_size_select    <= 1'b1;
      cfg.sector_program_mode <= 1'b0;
      cfg.manufacturer_code   <= 8'h62;
      cfg.device_code         <= 8'h13;
      regs.seq                <= fcs_pkg::SEQ_READY;
      regs.cmd                <= '0;
      regs.bank               <= 1'b0;
      regs.start              <= '0;
      regs.start_valid        <= 1'b0;
      changed_flag            <= 1'b0;
      rsp_valid               <= 1'b0;
    end else begin
      // register writes
      if (cfg_valid) begin
        unique case (cfg_index)
          fcs_pkg::CFG_CHIP_SIZE:    cfg.chip_size_select    <= cfg_data[0];
          fcs_pkg::CFG_SECTOR_PROG:  cfg.sector_program_mode <= cfg_data[0];
          fcs_pkg::CFG_MANUFACTURER: cfg.manufacturer_code   <= cfg_data;
          fcs_pkg::CFG_DEVICE:       cfg.device_code         <= cfg_data;
          default:                   cfg.device_code         <= cfg.device_code;
        endcase
      end

      // in the result phase a drained word is replaced below
      if (rsp_valid && rsp_ready && phase != PH_RESP) begin
        rsp_valid <= 1'b0;
      end

      unique case (phase)
        PH_CLEAR: begin
          if (sweep_done) begin
            phase <= PH_IDLE;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        PH_IDLE: begin
          if (accept) begin
            // sequence state moves at acceptance, flagged words leave it as is
            regs        <= dec.next;
            pend_status <= dec.status;
            pend_op     <= dec.op;
            pend_id     <= dec.id_data;
            if (dec.set_changed) begin
              changed_flag <= 1'b1;
            end
            if (dec.op == fcs_pkg::OP_ERASE) begin
              sweep_addr <= dec_addr;
              sweep_last <= dec_last;
              phase      <= PH_SWEEP;
            end else begin
              phase <= PH_RESP;
            end
          end
        end
        PH_SWEEP: begin
          if (sweep_done) begin
            phase <= PH_RESP;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        PH_RESP: begin
          // output register free or being drained this edge
          if (!rsp_valid || rsp_ready) begin
            rsp_valid            <= 1'b1;
            rsp.read_data        <= (pend_op == fcs_pkg::OP_READ) ? ram_rdata : pend_id;
            rsp.status           <= pend_status;
            rsp.contents_changed <= changed_flag;
            phase                <= PH_IDLE;
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

  // every accepted word leads to a result or an array walk
  `FCS_ASSERT_NEXT(a_accept_moves_on, clk, rst, accept,
                   phase == PH_RESP || phase == PH_SWEEP)
  // a flagged word changes no sequence state
  `FCS_ASSERT_NEXT(a_flag_keeps_state, clk, rst,
                   accept && dec.status != fcs_pkg::ST_OK, $stable(regs))
  // contents changed is sticky
  `FCS_ASSERT(a_changed_sticky, clk, rst, !$fell(changed_flag))
  // an erase walk never runs past its last byte
  `FCS_ASSERT(a_sweep_bounded, clk, rst, phase != PH_SWEEP || sweep_addr <= sweep_last)
  // a recorded sector start only lives inside sector program
  `FCS_ASSERT(a_start_in_sector, clk, rst,
              !regs.start_valid || regs.seq == fcs_pkg::SEQ_SECTOR_PROG)

endmodule

`default_nettype wire

[bench/flash_command_sequencer_tb.sv]
module flash_command_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FLASH_BYTES = 131072;
  // run limit: reset sweep, a handful of chip erases and many sector erases fit easily
  localparam int CYCLE_LIMIT = 3000000;
  localparam int PHASE_WORDS = 420;
  // first two bytes of every unlock sequence
  localparam logic [7:0] KEY_A = fcs_pkg::CMD_ERASE[23:16];
  localparam logic [7:0] KEY_B = fcs_pkg::CMD_ERASE[15:8];

  // shadow copy of the flash device: registers, command state and array
  class flash_shadow;
    localparam int BANK_BYTES = 32'h10000;

    logic                 two_banks;
    logic                 sector_mode;
    logic [7:0]           mfr_code;
    logic [7:0]           dev_code;
    fcs_pkg::seq_state_t  seq;
    logic [23:0]          cmd_bytes;
    logic                 bank;
    logic [15:0]          sector_base;
    logic                 sector_open;
    logic                 changed;
    logic [7:0]           mem [FLASH_BYTES];
    fcs_pkg::result_t     pending_results [$];
    int                   errors;

    function new();
      two_banks   = 1'b1;
      sector_mode = 1'b0;
      mfr_code    = 8'h62;
      dev_code    = 8'h13;
      seq         = fcs_pkg::SEQ_READY;
      cmd_bytes   = '0;
      bank        = 1'b0;
      sector_base = '0;
      sector_open = 1'b0;
      changed     = 1'b0;
      errors      = 0;
      foreach (mem[i]) mem[i] = fcs_pkg::ERASED_BYTE;
    endfunction

    function void set_reg(logic [1:0] idx, logic [7:0] val);
      case (idx)
        fcs_pkg::CFG_CHIP_SIZE:    two_banks = val[0];
        fcs_pkg::CFG_SECTOR_PROG:  sector_mode = val[0];
        fcs_pkg::CFG_MANUFACTURER: mfr_code = val;
        fcs_pkg::CFG_DEVICE:       dev_code = val;
        default: ;
      endcase
    endfunction

    function int capacity();
      int lim;
      lim = two_banks ? 2 * BANK_BYTES : BANK_BYTES;
      if (lim > FLASH_BYTES) lim = FLASH_BYTES;
      return lim;
    endfunction

    function int flat_index(logic [15:0] off);
      return int'(off) + ((two_banks && bank) ? BANK_BYTES : 0);
    endfunction

    function fcs_pkg::status_t apply_write(logic [15:0] off, logic [7:0] v);
      logic [23:0] c;
      int idx;
      int i;
      c = {cmd_bytes[15:0], v};
      case (seq)
        fcs_pkg::SEQ_READY, fcs_pkg::SEQ_ID: begin
          if (off != fcs_pkg::UNLOCK_A) return fcs_pkg::ST_BAD_SEQ;
          if (v == fcs_pkg::RESET_BYTE) begin
            seq = fcs_pkg::SEQ_READY;
          end else begin
            cmd_bytes = {16'h0000, v};
            seq = fcs_pkg::SEQ_CMD1;
          end
          return fcs_pkg::ST_OK;
        end
        fcs_pkg::SEQ_CMD1: begin
          if (off != fcs_pkg::UNLOCK_B) return fcs_pkg::ST_BAD_SEQ;
          cmd_bytes = c;
          seq = fcs_pkg::SEQ_CMD2;
          return fcs_pkg::ST_OK;
        end
        fcs_pkg::SEQ_CMD2: begin
          if (off != fcs_pkg::UNLOCK_A) return fcs_pkg::ST_BAD_SEQ;
          case (c)
            fcs_pkg::CMD_ID_ENTER: seq = fcs_pkg::SEQ_ID;
            fcs_pkg::CMD_ID_EXIT:  seq = fcs_pkg::SEQ_READY;
            fcs_pkg::CMD_BANK:     seq = fcs_pkg::SEQ_BANK;
            fcs_pkg::CMD_ERASE:    seq = fcs_pkg::SEQ_ERASE;
            fcs_pkg::CMD_PROGRAM:
              seq = sector_mode ? fcs_pkg::SEQ_SECTOR_PROG : fcs_pkg::SEQ_BYTE_PROG;
            default: return fcs_pkg::ST_UNKNOWN_CMD;
          endcase
          cmd_bytes = c;
          return fcs_pkg::ST_OK;
        end
        fcs_pkg::SEQ_ERASE: begin
          if (off != fcs_pkg::UNLOCK_A) return fcs_pkg::ST_BAD_SEQ;
          cmd_bytes = {16'h0000, v};
          seq = fcs_pkg::SEQ_ERASE1;
          return fcs_pkg::ST_OK;
        end
        fcs_pkg::SEQ_ERASE1: begin
          if (off != fcs_pkg::UNLOCK_B) return fcs_pkg::ST_BAD_SEQ;
          cmd_bytes = c;
          seq = fcs_pkg::SEQ_ERASE2;
          return fcs_pkg::ST_OK;
        end
        fcs_pkg::SEQ_ERASE2: begin
          if (off == fcs_pkg::UNLOCK_A && c == fcs_pkg::CMD_ERASE_CHIP) begin
            for (i = 0; i < capacity(); i++) mem[i] = fcs_pkg::ERASED_BYTE;
          end else begin
            idx = flat_index(off & fcs_pkg::SECTOR_MASK);
            if (idx + fcs_pkg::ERASE_SECTOR_BYTES > capacity()) return fcs_pkg::ST_RANGE;
            for (i = 0; i < fcs_pkg::ERASE_SECTOR_BYTES; i++) begin
              mem[idx + i] = fcs_pkg::ERASED_BYTE;
            end
          end
          cmd_bytes = c;
          changed = 1'b1;
          seq = fcs_pkg::SEQ_READY;
          return fcs_pkg::ST_OK;
        end
        fcs_pkg::SEQ_SECTOR_PROG: begin
          idx = flat_index(off);
          if (idx >= capacity()) return fcs_pkg::ST_RANGE;
          if (!sector_open) begin
            sector_base = off;
            sector_open = 1'b1;
          end
          mem[idx] = v;
          changed = 1'b1;
          // last byte of the 128-byte sector, offsets wrap at 16 bits
          if (16'(off - (fcs_pkg::PROGRAM_SECTOR_BYTES - 1)) == sector_base) begin
            sector_open = 1'b0;
            seq = fcs_pkg::SEQ_READY;
          end
          return fcs_pkg::ST_OK;
        end
        fcs_pkg::SEQ_BYTE_PROG: begin
          idx = flat_index(off);
          if (idx >= capacity()) return fcs_pkg::ST_RANGE;
          mem[idx] = v;
          changed = 1'b1;
          seq = fcs_pkg::SEQ_READY;
          return fcs_pkg::ST_OK;
        end
        fcs_pkg::SEQ_BANK: begin
          if (off != 16'h0000) return fcs_pkg::ST_BAD_SEQ;
          if (v > 8'd1) return fcs_pkg::ST_RANGE;
          bank = v[0];
          seq = fcs_pkg::SEQ_READY;
          return fcs_pkg::ST_OK;
        end
        default: return fcs_pkg::ST_OK;
      endcase
    endfunction

    function fcs_pkg::status_t apply_read(logic [15:0] off, output logic [7:0] data);
      int idx;
      data = 8'h00;
      case (seq)
        fcs_pkg::SEQ_ID: begin
          if (off == 16'h0000) begin
            data = mfr_code;
            return fcs_pkg::ST_OK;
          end
          if (off == 16'h0001) begin
            data = dev_code;
            return fcs_pkg::ST_OK;
          end
          return fcs_pkg::ST_RANGE;
        end
        fcs_pkg::SEQ_READY, fcs_pkg::SEQ_SECTOR_PROG: begin
          idx = flat_index(off);
          if (idx >= capacity()) return fcs_pkg::ST_RANGE;
          data = mem[idx];
          return fcs_pkg::ST_OK;
        end
        default: return fcs_pkg::ST_BUSY_READ;
      endcase
    endfunction

    function void note_access(fcs_pkg::access_t a);
      fcs_pkg::result_t r;
      fcs_pkg::status_t st;
      logic [7:0] data;
      data = 8'h00;
      if (a.mode) st = apply_write(a.offset, a.write_data);
      else st = apply_read(a.offset, data);
      if (st != fcs_pkg::ST_OK) data = 8'h00;
      r.read_data = data;
      r.status = st;
      r.contents_changed = changed;
      pending_results.push_back(r);
    endfunction

    function void check_result(fcs_pkg::result_t got);
      fcs_pkg::result_t want;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result word with none pending: data %h status %0d changed %b",
                 $time, got.read_data, got.status, got.contents_changed);
        return;
      end
      want = pending_results.pop_front();
      if (got.read_data !== want.read_data) begin
        errors++;
        $display("%0t: read_data expected %h actual %h", $time, want.read_data, got.read_data);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      end
      if (got.contents_changed !== want.contents_changed) begin
        errors++;
        $display("%0t: contents_changed expected %b actual %b", $time,
                 want.contents_changed, got.contents_changed);
      end
    endfunction

    function int pending();
      return pending_results.size();
    endfunction
  endclass

  // clock, reset and the block's ports
  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_ready;
  fcs_pkg::access_t req = '0;
  logic             rsp_valid;
  logic             rsp_ready = 1'b0;
  fcs_pkg::result_t rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = '0;
  logic [7:0]       cfg_data = '0;

  flash_shadow shadow;

  // sender pacing and bookkeeping
  int   burst_left = 1;
  int   words_sent = 0;
  int   words_accepted = 0;
  int   cycles = 0;
  logic sector_mode_on = 1'b0;

  // receiver stall pattern
  int   ready_pct = 100;
  int   pattern_left = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;

  always #10 clk = ~clk;

  flash_command_sequencer #(.ARRAY_BYTES(FLASH_BYTES)) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // watchdog on the whole run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // monitor: register writes, access words and result words as seen at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) shadow.set_reg(cfg_index, cfg_data);
      if (req_valid && req_ready) begin
        shadow.note_access(req);
        words_accepted++;
      end
      if (rsp_valid && rsp_ready) shadow.check_result(rsp);
    end
  end

  // receiver: stall pattern changes every so often, one long hold-off early on
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      rsp_ready <= 1'b0;
    end else if (!hold_done && words_accepted >= 150) begin
      // long hold-off so the block backs up and stalls its input
      hold_done = 1'b1;
      hold_left = 400;
      rsp_ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        case ($urandom_range(0, 3))
          0: ready_pct = 100;
          1: ready_pct = 75;
          2: ready_pct = 50;
          default: ready_pct = 15;
        endcase
        pattern_left = $urandom_range(20, 300);
      end else begin
        pattern_left--;
      end
      rsp_ready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  // offer one access word and wait for it to be taken; valid stays up for a
  // following word unless the burst ends here
  task automatic send_word(input logic m, input logic [15:0] o, input logic [7:0] d);
    fcs_pkg::access_t a;
    a.mode = m;
    a.offset = o;
    a.write_data = d;
    req <= a;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    words_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      // now and then a long burst with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
    end
  endtask

  task automatic write_word(input logic [15:0] o, input logic [7:0] d);
    send_word(1'b1, o, d);
  endtask

  task automatic read_word(input logic [15:0] o);
    send_word(1'b0, o, 8'($urandom));
  endtask

  task automatic unlock_cmd(input logic [7:0] c);
    write_word(fcs_pkg::UNLOCK_A, KEY_A);
    write_word(fcs_pkg::UNLOCK_B, KEY_B);
    write_word(fcs_pkg::UNLOCK_A, c);
  endtask

  // one register write; valid stays high for the next one
  task automatic put_reg(input logic [1:0] idx, input logic [7:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // unused upper bits of the one-bit registers get random values
  task automatic set_config(input logic two_banks, input logic sector_mode,
                            input logic [7:0] mfr, input logic [7:0] dev);
    put_reg(fcs_pkg::CFG_CHIP_SIZE, {7'($urandom), two_banks});
    put_reg(fcs_pkg::CFG_SECTOR_PROG, {7'($urandom), sector_mode});
    put_reg(fcs_pkg::CFG_MANUFACTURER, mfr);
    put_reg(fcs_pkg::CFG_DEVICE, dev);
    cfg_valid <= 1'b0;
    sector_mode_on = sector_mode;
  endtask

  // offsets cluster on a few sectors so programs, erases and reads meet
  function automatic logic [15:0] pick_offset();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return {8'h00, 8'($urandom)};
    if (r < 65) return {8'hFF, 8'($urandom)};
    if (r < 75) return {4'h5, 12'($urandom)};
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] noise_offset();
    case ($urandom_range(0, 4))
      0: return fcs_pkg::UNLOCK_A;
      1: return fcs_pkg::UNLOCK_B;
      2: return 16'($urandom_range(0, 1));
      3: return pick_offset();
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] noise_data();
    case ($urandom_range(0, 9))
      0: return KEY_A;
      1: return KEY_B;
      2: return fcs_pkg::CMD_ID_ENTER[7:0];
      3: return fcs_pkg::CMD_BANK[7:0];
      4: return fcs_pkg::RESET_BYTE;
      5: return 8'($urandom_range(0, 1));
      default: return 8'($urandom);
    endcase
  endfunction

  // the program command in sector mode, 128 consecutive offsets from base
  task automatic sector_program(input logic [15:0] base);
    int k;
    unlock_cmd(fcs_pkg::CMD_PROGRAM[7:0]);
    for (k = 0; k < fcs_pkg::PROGRAM_SECTOR_BYTES; k++) begin
      if ($urandom_range(0, 15) == 0) read_word(pick_offset());
      write_word(base + 16'(k), 8'($urandom));
    end
    repeat (3) begin
      read_word(base + 16'($urandom_range(0, fcs_pkg::PROGRAM_SECTOR_BYTES - 1)));
    end
  endtask

  // erase of the 4 KiB sector holding o; never the chip erase combination
  task automatic sector_erase(input logic [15:0] o, input logic [7:0] d);
    logic [7:0] last;
    last = d;
    if (o == fcs_pkg::UNLOCK_A && last == fcs_pkg::CMD_ERASE_CHIP[7:0]) last = ~last;
    unlock_cmd(fcs_pkg::CMD_ERASE[7:0]);
    write_word(fcs_pkg::UNLOCK_A, KEY_A);
    write_word(fcs_pkg::UNLOCK_B, KEY_B);
    write_word(o, last);
  endtask

  task automatic random_sequence();
    int kind;
    int n;
    int k;
    logic [15:0] o;
    logic [7:0] d;
    kind = $urandom_range(0, 99);
    if (kind < 22) begin
      n = $urandom_range(1, 4);
      for (k = 0; k < n; k++) read_word(pick_offset());
    end else if (kind < 30) begin
      // id mode, left by the exit command or by the reset byte
      unlock_cmd(fcs_pkg::CMD_ID_ENTER[7:0]);
      read_word(16'h0000);
      read_word(16'h0001);
      read_word(pick_offset());
      if ($urandom_range(0, 1)) unlock_cmd(fcs_pkg::CMD_ID_EXIT[7:0]);
      else write_word(fcs_pkg::UNLOCK_A, fcs_pkg::RESET_BYTE);
    end else if (kind < 46) begin
      if (!sector_mode_on) begin
        o = pick_offset();
        unlock_cmd(fcs_pkg::CMD_PROGRAM[7:0]);
        write_word(o, 8'($urandom));
        read_word(o);
      end else if ($urandom_range(0, 9) == 0) begin
        if ($urandom_range(0, 3) == 0) sector_program(16'hFF80 + 16'($urandom_range(1, 127)));
        else sector_program(pick_offset());
      end else begin
        read_word(pick_offset());
      end
    end else if (kind < 54) begin
      unlock_cmd(fcs_pkg::CMD_BANK[7:0]);
      case ($urandom_range(0, 3))
        0: write_word(16'($urandom_range(1, 65535)), 8'($urandom));
        1: write_word(16'h0000, 8'($urandom_range(2, 255)));
        2: read_word(pick_offset());
        default: ;
      endcase
      write_word(16'h0000, 8'($urandom_range(0, 1)));
    end else if (kind < 60) begin
      o = ($urandom_range(0, 3) == 0) ? fcs_pkg::UNLOCK_A : pick_offset();
      sector_erase(o, 8'($urandom));
      read_word(o);
    end else if (kind < 65) begin
      write_word(fcs_pkg::UNLOCK_A, fcs_pkg::RESET_BYTE);
    end else if (kind < 75) begin
      // third byte that names no command, then the exit command byte
      d = 8'($urandom);
      if (d inside {fcs_pkg::CMD_ID_ENTER[7:0], fcs_pkg::CMD_ID_EXIT[7:0],
                    fcs_pkg::CMD_BANK[7:0], fcs_pkg::CMD_ERASE[7:0],
                    fcs_pkg::CMD_PROGRAM[7:0]}) d = d ^ 8'h01;
      if ($urandom_range(0, 7) == 0) d = fcs_pkg::CMD_ERASE_CHIP[7:0];
      unlock_cmd(d);
      write_word(fcs_pkg::UNLOCK_A, fcs_pkg::CMD_ID_EXIT[7:0]);
    end else if (kind < 88) begin
      // broken sequences: reads while busy, wrong unlock offsets
      case ($urandom_range(0, 3))
        0: begin
          write_word(fcs_pkg::UNLOCK_A, KEY_A);
          read_word(pick_offset());
          write_word(pick_offset(), KEY_B);
        end
        1: begin
          unlock_cmd(fcs_pkg::CMD_ERASE[7:0]);
          read_word(pick_offset());
          write_word(fcs_pkg::UNLOCK_A, KEY_A);
          write_word(pick_offset(), KEY_B);
        end
        2: begin
          if (!sector_mode_on) begin
            unlock_cmd(fcs_pkg::CMD_PROGRAM[7:0]);
            read_word(pick_offset());
            write_word(pick_offset(), 8'($urandom));
          end else begin
            unlock_cmd(fcs_pkg::CMD_BANK[7:0]);
            read_word(pick_offset());
            write_word(16'h0000, 8'($urandom_range(0, 1)));
          end
        end
        default: begin
          o = pick_offset();
          if (o == fcs_pkg::UNLOCK_A) o = ~o;
          write_word(o, KEY_A);
        end
      endcase
    end else begin
      n = $urandom_range(1, 3);
      for (k = 0; k < n; k++) send_word(1'($urandom), noise_offset(), noise_data());
    end
  endtask

  // two plain reads queue behind any erase walk; once their results are
  // back and a few cycles pass, the block is idle
  task automatic end_phase();
    read_word(pick_offset());
    read_word(pick_offset());
    req_valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input logic two_banks, input logic sector_mode,
                           input logic [7:0] mfr, input logic [7:0] dev);
    int first;
    set_config(two_banks, sector_mode, mfr, dev);
    first = words_sent;
    // a wrapping sector program whenever sector mode is on, and a sector erase
    if (sector_mode) sector_program(16'hFF80 + 16'($urandom_range(1, 127)));
    sector_erase(pick_offset(), 8'($urandom));
    while (words_sent - first < PHASE_WORDS) random_sequence();
    end_phase();
  endtask

  initial begin
    shadow = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part with reset register values: two banks, byte program
    read_word(16'h0000);
    // id mode, codes at offsets 0 and 1, any other offset out of range
    unlock_cmd(fcs_pkg::CMD_ID_ENTER[7:0]);
    read_word(16'h0000);
    read_word(16'h0001);
    read_word(16'hFFFF);
    // reset byte leaves id mode
    write_word(fcs_pkg::UNLOCK_A, fcs_pkg::RESET_BYTE);
    // read while busy, wrong second unlock offset, then the program command
    write_word(fcs_pkg::UNLOCK_A, KEY_A);
    read_word(16'h0000);
    write_word(16'h5556, KEY_B);
    write_word(fcs_pkg::UNLOCK_B, KEY_B);
    write_word(fcs_pkg::UNLOCK_A, fcs_pkg::CMD_PROGRAM[7:0]);
    write_word(16'hFFFF, 8'h00);
    // bank switch: wrong offset, value too big, then bank 1
    unlock_cmd(fcs_pkg::CMD_BANK[7:0]);
    write_word(16'h0001, 8'h01);
    write_word(16'h0000, 8'hFF);
    write_word(16'h0000, 8'h01);
    read_word(16'hFFFF);
    // chip erase byte outside an erase is unknown, erase byte follows in the same step
    unlock_cmd(fcs_pkg::CMD_ERASE_CHIP[7:0]);
    write_word(fcs_pkg::UNLOCK_A, fcs_pkg::CMD_ERASE[7:0]);
    // chip erase
    unlock_cmd(fcs_pkg::CMD_ERASE_CHIP[7:0]);
    end_phase();

    // random phases over the register settings, extremes of the id codes
    run_phase(1'b1, 1'b0, 8'($urandom), 8'($urandom));
    run_phase(1'b0, 1'b1, 8'h00, 8'hFF);
    run_phase(1'b1, 1'b1, 8'hFF, 8'h00);
    run_phase(1'b0, 1'b0, 8'($urandom), 8'($urandom));

    repeat (20) @(posedge clk);
    if (shadow.errors == 0 && shadow.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+design
design/fcs_pkg.sv
design/fcs_ram.sv
design/fcs_decode.sv
design/flash_command_sequencer.sv
bench/flash_command_sequencer_tb.sv
